@@ src/tsmt_pkg.sv @@
// Shared widths, codes and handshake structs for the time-slice multiplicity trigger.
`default_nettype none

package tsmt_pkg;

    localparam int TIME_W     = 20;
    localparam int SLICE_W    = 19;
    localparam int THR_W      = 10;
    localparam int WGT_W      = 16;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int END_W      = 21;
    localparam int WTS_W      = 47;
    localparam int WSUM_W     = 27;
    localparam int PROD_W     = TIME_W + WGT_W + 1;
    localparam int QUO_W      = TIME_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
    localparam int MAX_HITS   = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 56;

    localparam logic [SLICE_W-1:0] SLICE_WIDTH_RST = SLICE_W'(1600);
    localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(2);
    localparam logic [WGT_W-1:0]   WGT_TRACKER_RST = WGT_W'(256);
    localparam logic [WGT_W-1:0]   WGT_TIMING_RST  = WGT_W'(4096);

    typedef enum logic [CMD_W-1:0] {
        CMD_HIT       = 2'd0,
        CMD_CLOSE     = 2'd1,
        CMD_NEW_EVENT = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE_WIDTH     = 2'd0,
        CFG_COUNT_THRESHOLD = 2'd1,
        CFG_WEIGHT_TRACKER  = 2'd2,
        CFG_WEIGHT_TIMING   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [WTS_W-1:0]  dividend;
        logic [WSUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ src/tsmt_div.sv @@
// Iterative restoring divider: one compare-and-subtract per cycle, one quotient bit a step.
`default_nettype none

module tsmt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsmt_pkg::div_req_t req,
    output tsmt_pkg::div_rsp_t rsp
);
    import tsmt_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WSUM_W-1:0]    rem_reg;
    logic [WSUM_W-1:0]    dsr_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [WSUM_W:0]      trial;
    logic [WSUM_W+1:0]    diff;
    logic                 fits;

    // quotient is known to fit QUO_W bits, so the top of the dividend starts as remainder
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign fits  = ~diff[WSUM_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(QUO_W);
                rem_reg  <= req.dividend[WTS_W-1:QUO_W];
                quo_reg  <= req.dividend[QUO_W-1:0];
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_rem_below_dsr: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < dsr_reg)
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");

endmodule

`default_nettype wire

@@ src/time_slice_multiplicity_trigger.sv @@
// Top level: hit accumulation, slice sequencing and report formatting.
// A counted hit word passes through accept, a multiply of time by weight and an add to the
// weighted sum; a late hit, a hit beyond a full count, a new-event word and an unused code
// need only the accept. A close word with no division needed goes from accept to loading
// the report; when the slice triggers with a non-zero weight sum it goes through accept,
// loading the divider, the divider resolving the quotient one bit at a time, taking the
// result and loading the report. s_tready is low while a word is being worked on. A report
// sits in the output register until taken; further hits are still accepted meanwhile, and
// a following close waits for the register to empty.
`default_nettype none

module time_slice_multiplicity_trigger (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tsmt_pkg::S_TDATA_W-1:0]     s_tdata,   // hit_time[19:0], zero pad
    input  logic [tsmt_pkg::S_TUSER_W-1:0]     s_tuser,   // cmd[1:0], det_class[2]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // triggered[0], mean_time[20:1], slice_number[30:21], hits_in_slice[41:31],
    // late_hits[52:42], zero pad
    output logic [tsmt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_we,
    input  logic [tsmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsmt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tsmt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_HITS);
    localparam logic [END_W-1:0] END_SAT  = '1;

    state_t             state_reg;

    logic [SLICE_W-1:0] slice_width_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [WGT_W-1:0]   wgt_tracker_reg;
    logic [WGT_W-1:0]   wgt_timing_reg;

    logic [IDX_W-1:0]   slice_index_reg;
    logic [END_W-1:0]   slice_end_reg;
    logic [CNT_W-1:0]   hit_count_reg;
    logic [CNT_W-1:0]   late_count_reg;
    logic [WTS_W-1:0]   wts_reg;
    logic [WSUM_W-1:0]  wsum_reg;

    logic [TIME_W-1:0]  t_reg;
    logic [WGT_W-1:0]   w_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic               snap_trig_reg;
    logic               snap_neg_reg;
    logic [IDX_W-1:0]   snap_index_reg;
    logic [CNT_W-1:0]   snap_hits_reg;
    logic [CNT_W-1:0]   snap_late_reg;
    logic [TIME_W-1:0]  mean_reg;

    logic               div_start_reg;
    logic [WTS_W-1:0]   dividend_reg;
    logic [WSUM_W-1:0]  divisor_reg;

    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [TIME_W-1:0]  in_time;
    logic               in_class;
    logic [WGT_W-1:0]   in_wgt;
    logic               in_slice;
    logic               accept;
    logic               trig_now;
    logic [WTS_W-1:0]   half_wsum;
    logic [END_W:0]     end_sum;
    logic               out_free;

    assign in_time   = s_tdata[TIME_W-1:0];
    assign in_class  = s_tuser[CMD_W];
    assign in_wgt    = in_class ? wgt_timing_reg : wgt_tracker_reg;
    // negative times always fall inside the slice
    assign in_slice  = in_time[TIME_W-1] |
                       ({{(END_W-TIME_W+1){1'b0}}, in_time[TIME_W-2:0]} < slice_end_reg);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign trig_now  = hit_count_reg > {{(CNT_W-THR_W){1'b0}}, threshold_reg};
    assign half_wsum = {{(WTS_W-WSUM_W+1){1'b0}}, wsum_reg[WSUM_W-1:1]};
    assign end_sum   = {1'b0, slice_end_reg} + {{(END_W-SLICE_W+1){1'b0}}, slice_width_reg};
    assign out_free  = ~m_valid_reg | m_tready;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = divisor_reg;

    tsmt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_width_reg <= SLICE_WIDTH_RST;
            threshold_reg   <= THRESHOLD_RST;
            wgt_tracker_reg <= WGT_TRACKER_RST;
            wgt_timing_reg  <= WGT_TIMING_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SLICE_WIDTH:     slice_width_reg <= cfg_wdata[SLICE_W-1:0];
                CFG_COUNT_THRESHOLD: threshold_reg   <= cfg_wdata[THR_W-1:0];
                CFG_WEIGHT_TRACKER:  wgt_tracker_reg <= cfg_wdata[WGT_W-1:0];
                CFG_WEIGHT_TIMING:   wgt_timing_reg  <= cfg_wdata[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            slice_index_reg <= '0;
            slice_end_reg   <= {{(END_W-SLICE_W){1'b0}}, SLICE_WIDTH_RST};
            hit_count_reg   <= '0;
            late_count_reg  <= '0;
            wts_reg         <= '0;
            wsum_reg        <= '0;
            div_start_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            // in ST_OUT a taken report is replaced below
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (cmd_t'(s_tuser[CMD_W-1:0]))
                            CMD_HIT: begin
                                t_reg <= in_time;
                                w_reg <= in_wgt;
                                if (in_slice) begin
                                    if (hit_count_reg < MAX_CNT) begin
                                        hit_count_reg <= hit_count_reg + 1'b1;
                                        wsum_reg      <= wsum_reg +
                                            {{(WSUM_W-WGT_W){1'b0}}, in_wgt};
                                        state_reg     <= ST_MUL;
                                    end
                                end else if (late_count_reg < MAX_CNT) begin
                                    late_count_reg <= late_count_reg + 1'b1;
                                end
                            end
                            CMD_CLOSE: begin
                                snap_trig_reg  <= trig_now;
                                snap_neg_reg   <= wts_reg[WTS_W-1];
                                snap_index_reg <= slice_index_reg;
                                snap_hits_reg  <= hit_count_reg;
                                snap_late_reg  <= late_count_reg;
                                mean_reg       <= '0;
                                // |sum| + wsum/2, folded into one add or subtract
                                dividend_reg   <= wts_reg[WTS_W-1] ? (half_wsum - wts_reg)
                                                                   : (half_wsum + wts_reg);
                                divisor_reg    <= wsum_reg;
                                if (trig_now && (wsum_reg != '0)) begin
                                    div_start_reg <= 1'b1;
                                    state_reg     <= ST_DIV;
                                end else begin
                                    state_reg     <= ST_OUT;
                                end
                                hit_count_reg   <= '0;
                                late_count_reg  <= '0;
                                wts_reg         <= '0;
                                wsum_reg        <= '0;
                                slice_index_reg <= slice_index_reg + 1'b1;
                                slice_end_reg   <= end_sum[END_W] ? END_SAT
                                                                  : end_sum[END_W-1:0];
                            end
                            CMD_NEW_EVENT: begin
                                slice_index_reg <= '0;
                                slice_end_reg   <= {{(END_W-SLICE_W){1'b0}}, slice_width_reg};
                                hit_count_reg   <= '0;
                                late_count_reg  <= '0;
                                wts_reg         <= '0;
                                wsum_reg        <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'($signed(t_reg) * $signed({1'b0, w_reg}));
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    wts_reg   <= wts_reg + {{(WTS_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                    state_reg <= ST_IDLE;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        mean_reg  <= snap_neg_reg ? (TIME_W'(0) - div_rsp.quotient)
                                                  : div_rsp.quotient;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{(M_TDATA_W-1-TIME_W-IDX_W-2*CNT_W){1'b0}},
                                        snap_late_reg, snap_hits_reg, snap_index_reg,
                                        mean_reg, snap_trig_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_count_reg <= MAX_CNT) && (late_count_reg <= MAX_CNT))
        else $error("slice counter beyond saturation");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> (divisor_reg != '0) && (state_reg == ST_DIV))
        else $error("division started without weight");

    a_report_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("report raised outside output state");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Stream testbench for the time-slice multiplicity trigger: queued words, model, checks.
`timescale 1ns / 1ps

module testbench;
    import tsmt_pkg::*;

    localparam int     LIMIT_CYCLES   = 1_000_000;
    localparam int     QUIET_CYCLES   = 40;
    localparam int     RX_HOLD_CYCLES = 300;
    localparam longint END_MAX        = (longint'(1) << END_W) - 1;
    localparam longint T_MAX          = 524287;
    localparam longint T_MIN          = -524288;
    localparam longint SLICE_MAX      = 524287;
    localparam longint WGT_MAX        = 65535;
    localparam longint THR_MAX        = 1023;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic   DET_TRACKER    = 1'b0;
    localparam logic   DET_TIMING     = 1'b1;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [TIME_W-1:0] t;
        logic                     cls;
    } hit_word_t;

    // last field in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [CNT_W-1:0]  late;
        logic [CNT_W-1:0]  hits;
        logic [IDX_W-1:0]  slice;
        logic [TIME_W-1:0] mean;
        logic              trig;
    } slice_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    time_slice_multiplicity_trigger dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hit_word_t     words_to_send[$];
    slice_report_t reports_due[$];
    hit_word_t     cur_word;
    bit            slot_busy    = 1'b0;
    bit            tx_gaps_on   = 1'b1;
    bit            rx_gaps_on   = 1'b1;
    int            tx_gap       = 0;
    int            rx_gap       = 0;
    int            rx_hold      = 0;
    int            holds_left   = 2;
    int            next_hold_at = 40;
    int            reports_seen = 0;
    int            errors       = 0;
    int            cycles       = 0;
    int            n_words      = 0;

    // register copies and slice state of the model
    longint c_width = longint'(SLICE_WIDTH_RST);
    longint c_thr   = longint'(THRESHOLD_RST);
    longint c_wtrk  = longint'(WGT_TRACKER_RST);
    longint c_wtim  = longint'(WGT_TIMING_RST);
    longint m_idx   = 0;
    longint m_end   = longint'(SLICE_WIDTH_RST);
    longint m_hits  = 0;
    longint m_late  = 0;
    longint m_wts   = 0;
    longint m_wsum  = 0;

    // generator's own view of the slice window, mirrored word by word
    longint g_width = longint'(SLICE_WIDTH_RST);
    longint g_end   = longint'(SLICE_WIDTH_RST);

    function automatic logic rand_cls();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic longint rand_range(input int unsigned lo, input int unsigned hi);
        return longint'($urandom_range(lo, hi));
    endfunction

    task automatic clear_tally();
        m_hits = 0;
        m_late = 0;
        m_wts  = 0;
        m_wsum = 0;
    endtask

    task automatic slice_tally(input hit_word_t w);
        longint        t;
        longint        wgt;
        longint        mag;
        longint        q;
        longint        nxt;
        slice_report_t rep;
        case (w.cmd)
            CMD_HIT: begin
                t   = longint'(w.t);
                wgt = (w.cls == DET_TIMING) ? c_wtim : c_wtrk;
                if (t < m_end) begin
                    // a full counter freezes both sums too
                    if (m_hits < MAX_HITS) begin
                        m_hits++;
                        m_wsum += wgt;
                        m_wts  += t * wgt;
                    end
                end else if (m_late < MAX_HITS) begin
                    m_late++;
                end
            end
            CMD_CLOSE: begin
                rep.trig = m_hits > c_thr;
                q = 0;
                if (rep.trig && m_wsum != 0) begin
                    // halves round away from zero
                    mag = (m_wts < 0) ? -m_wts : m_wts;
                    q   = (mag + m_wsum / 2) / m_wsum;
                    if (m_wts < 0)
                        q = -q;
                end
                rep.mean  = q[TIME_W-1:0];
                rep.slice = m_idx[IDX_W-1:0];
                rep.hits  = m_hits[CNT_W-1:0];
                rep.late  = m_late[CNT_W-1:0];
                reports_due = {reports_due, rep};
                clear_tally();
                m_idx = (m_idx + 1) % 1024;
                nxt   = m_end + c_width;
                m_end = (nxt > END_MAX) ? END_MAX : nxt;
            end
            CMD_NEW_EVENT: begin
                m_idx = 0;
                m_end = c_width;
                clear_tally();
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input slice_report_t e,
                                 input slice_report_t a);
        errors++;
        if (errors <= 10) begin
            $write("%s: expected trig=%0b mean=%0d slice=%0d hits=%0d late=%0d, ",
                   what, e.trig, $signed(e.mean), e.slice, e.hits, e.late);
            $display("got trig=%0b mean=%0d slice=%0d hits=%0d late=%0d",
                     a.trig, $signed(a.mean), a.slice, a.hits, a.late);
        end
    endtask

    // checks come before the model update; a report cannot leave in its own accept cycle
    always @(posedge aclk) begin : observer
        slice_report_t got;
        slice_report_t want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = slice_report_t'(m_tdata[$bits(slice_report_t)-1:0]);
                reports_seen++;
                if (reports_due.size() == 0) begin
                    note_mismatch("unexpected report", '0, got);
                end else begin
                    want = reports_due.pop_front();
                    if (got.trig != want.trig || got.mean != want.mean ||
                        got.slice != want.slice || got.hits != want.hits ||
                        got.late != want.late)
                        note_mismatch("report mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                slice_tally(cur_word);
                slot_busy = 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : sender
        logic offer;
        offer = 1'b0;
        if (aresetn && !slot_busy) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (words_to_send.size() != 0) begin
                if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
                    tx_gap = $urandom_range(0, 11);
                end else begin
                    cur_word = words_to_send.pop_front();
                    s_tdata  <= {{(S_TDATA_W-TIME_W){1'b0}}, cur_word.t};
                    s_tuser  <= {cur_word.cls, cur_word.cmd};
                    offer     = 1'b1;
                    slot_busy = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    always @(negedge aclk) begin : receiver
        logic ready;
        ready = 1'b1;
        // long hold: the output register fills and the next close backs up the input
        if (holds_left > 0 && reports_seen >= next_hold_at) begin
            rx_hold = RX_HOLD_CYCLES;
            holds_left--;
            next_hold_at += 1400;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            ready = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            ready = 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
            rx_gap = $urandom_range(0, 11);
            ready  = 1'b0;
        end
        m_tready <= ready;
    end

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input longint t, input logic cls);
        hit_word_t w;
        longint    nxt;
        w.cmd = cmd;
        w.t   = TIME_W'((t > T_MAX) ? T_MAX : ((t < T_MIN) ? T_MIN : t));
        w.cls = cls;
        words_to_send = {words_to_send, w};
        n_words++;
        if (cmd == CMD_CLOSE) begin
            nxt   = g_end + g_width;
            g_end = (nxt > END_MAX) ? END_MAX : nxt;
        end else if (cmd == CMD_NEW_EVENT) begin
            g_end = g_width;
        end
    endtask

    function automatic longint in_slice_time();
        if ($urandom_range(0, 7) == 0)
            return g_end - 1;
        return g_end - g_width + longint'($urandom_range(0, int'(g_width - 1)));
    endfunction

    function automatic longint late_time();
        if ($urandom_range(0, 3) == 0)
            return g_end;
        return g_end + longint'($urandom_range(0, int'(g_width)));
    endfunction

    task automatic push_noise();
        queue_word(CMD_W'($urandom_range(0, 3)),
                   longint'($urandom_range(0, 1048575)) - 524288, rand_cls());
    endtask

    task automatic gen_slice(input int nhits, input int late_pct);
        int r;
        for (int i = 0; i < nhits; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                push_noise();
            else if (r < 6 + late_pct)
                queue_word(CMD_HIT, late_time(), rand_cls());
            else
                queue_word(CMD_HIT, in_slice_time(), rand_cls());
        end
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
    endtask

    task automatic gen_event(input int nslices, input bit fresh);
        if (fresh)
            queue_word(CMD_NEW_EVENT, 0, DET_TRACKER);
        for (int i = 0; i < nslices; i++)
            gen_slice($urandom_range(0, 10), $urandom_range(0, 30));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input longint val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
    endtask

    // only called with nothing in flight; slice_end keeps its value until the next close or new event
    task automatic set_regs(input longint width, input longint thr, input longint wtrk,
                            input longint wtim);
        write_reg(CFG_SLICE_WIDTH, width);
        write_reg(CFG_COUNT_THRESHOLD, thr);
        write_reg(CFG_WEIGHT_TRACKER, wtrk);
        write_reg(CFG_WEIGHT_TIMING, wtim);
        @(negedge aclk);
        cfg_we  <= 1'b0;
        c_width = width;
        c_thr   = thr;
        c_wtrk  = wtrk;
        c_wtim  = wtim;
        g_width = width;
    endtask

    task automatic wait_quiet();
        while (words_to_send.size() != 0 || slot_busy || s_tvalid || reports_due.size() != 0)
            @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int start;
        int ins;
        int lates;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: time extremes, slice boundary, unused code, rounding of halves
        queue_word(CMD_HIT, T_MIN, DET_TIMING);
        queue_word(CMD_HIT, T_MAX, DET_TRACKER);
        queue_word(CMD_HIT, 0, DET_TRACKER);
        queue_word(CMD_HIT, 1599, DET_TIMING);
        queue_word(CMD_HIT, 1600, DET_TRACKER);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        queue_word(CMD_UNUSED, T_MAX, DET_TIMING);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        queue_word(CMD_NEW_EVENT, 0, DET_TRACKER);
        queue_word(CMD_HIT, 0, DET_TRACKER);
        queue_word(CMD_HIT, 0, DET_TRACKER);
        queue_word(CMD_HIT, 1, DET_TRACKER);
        queue_word(CMD_HIT, 1, DET_TRACKER);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        queue_word(CMD_HIT, -1, DET_TRACKER);
        queue_word(CMD_HIT, -1, DET_TRACKER);
        queue_word(CMD_HIT, 0, DET_TRACKER);
        queue_word(CMD_HIT, 0, DET_TRACKER);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        queue_word(CMD_HIT, -1, DET_TIMING);
        queue_word(CMD_UNUSED, -1, DET_TRACKER);
        queue_word(CMD_NEW_EVENT, 0, DET_TRACKER);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        wait_quiet();

        // largest weights on extreme times, late hits mixed in
        set_regs(100000, 0, WGT_MAX, WGT_MAX);
        queue_word(CMD_NEW_EVENT, 0, DET_TRACKER);
        ins   = 40;
        lates = 40;
        while (ins + lates > 0) begin
            if (lates == 0 || (ins > 0 && $urandom_range(0, 1) == 0)) begin
                queue_word(CMD_HIT, ($urandom_range(0, 1) == 0) ? T_MIN : in_slice_time(),
                           rand_cls());
                ins--;
            end else begin
                queue_word(CMD_HIT, late_time(), rand_cls());
                lates--;
            end
        end
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        wait_quiet();

        // widest slices: slice end saturates; first close still uses the old end
        set_regs(SLICE_MAX, 0, 1, WGT_MAX);
        queue_word(CMD_CLOSE, 0, DET_TRACKER);
        queue_word(CMD_NEW_EVENT, 0, DET_TRACKER);
        for (int i = 0; i < 7; i++)
            gen_slice($urandom_range(0, 3), 20);
        wait_quiet();

        // one-unit slices
        set_regs(1, 1, WGT_MAX, 1);
        gen_event(10, 1'b1);
        wait_quiet();

        // long run of short, mostly empty slices
        set_regs(300, 0, rand_range(1, 65535), rand_range(1, 65535));
        queue_word(CMD_NEW_EVENT, 0, DET_TRACKER);
        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(0, 5) == 0)
                queue_word(CMD_HIT, in_slice_time(), rand_cls());
            queue_word(CMD_CLOSE, 0, DET_TRACKER);
        end
        wait_quiet();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                set_regs(1, 0, 1, 1);
            else if (ph == 1)
                set_regs(SLICE_MAX, THR_MAX, WGT_MAX, WGT_MAX);
            else
                set_regs(($urandom_range(0, 5) == 0) ? rand_range(1, 524287)
                                                     : rand_range(1, 5000),
                         rand_range(0, 6), rand_range(1, 65535),
                         rand_range(1, 65535));
            tx_gaps_on = (ph != 5) && ($urandom_range(0, 3) != 0);
            rx_gaps_on = (ph != 5) && ($urandom_range(0, 3) != 0);
            start = n_words;
            while (n_words - start < 40)
                gen_event($urandom_range(1, 4), $urandom_range(0, 9) != 0);
            wait_quiet();
        end

        if (errors == 0 && reports_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ time_slice_multiplicity_trigger.f @@
src/tsmt_pkg.sv
src/tsmt_div.sv
src/time_slice_multiplicity_trigger.sv
tb/sv/testbench.sv
